// ----- src/ctcgd_pkg.sv -----
// Shared types and constants of the CTC greedy plate decoder.
package ctcgd_pkg;

  localparam int unsigned PROB_W     = 16;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned LABEL_ID_W = 7;
  localparam int unsigned LIMIT_W    = 7;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LABEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] LABEL_COUNT_RST = 8'd84;
  localparam logic [LIMIT_W-1:0]    RANGE_LOW_RST   = 7'd31;
  localparam logic [LIMIT_W-1:0]    RANGE_HIGH_RST  = 7'd63;

  localparam logic KIND_SYMBOL  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One finished time step as seen by the back end.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PROB_W-1:0] conf;
    logic              sym;
    logic              eos;
  } event_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SYM,
    BK_DIV,
    BK_WAIT,
    BK_SUM
  } back_state_e;

  typedef enum logic [1:0] {
    LS_NONE,
    LS_HELD,
    LS_PASS
  } lead_stage_e;

endpackage

// ----- src/ctcgd_if.sv -----
// Stream interfaces for label probabilities in and decoded results out.
interface ctcgd_in_if;
  import ctcgd_pkg::*;

  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] probability;
  logic              end_of_sequence;

  modport source (output valid, output probability, output end_of_sequence, input ready);
  modport sink (input valid, input probability, input end_of_sequence, output ready);
endinterface

interface ctcgd_out_if;
  import ctcgd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [LABEL_ID_W-1:0] label_id;
  logic [PROB_W-1:0]     confidence;
  logic [PROB_W-1:0]     average_confidence;
  logic                  no_symbols;
  logic                  last;

  modport source (output valid, output kind, output label_id, output confidence,
                  output average_confidence, output no_symbols, output last,
                  input ready);
  modport sink (input valid, input kind, input label_id, input confidence,
                input average_confidence, input no_symbols, input last,
                output ready);
endinterface

// ----- src/ctcgd_front.sv -----
// Front end: per-step argmax scan, blank and repeat filtering, event generation.
module ctcgd_front #(
  parameter int unsigned MAX_LABELS = 128,
  parameter int unsigned PROB_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ctcgd_in_if.sink                        in_ch,
  input  logic [ctcgd_pkg::CFG_DATA_W-1:0] label_count_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output ctcgd_pkg::event_t               ev_o
);
  import ctcgd_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_LABELS);
  localparam logic [PROB_W-1:0] ProbMask =
    (PROB_BITS >= PROB_W) ? {PROB_W{1'b1}} : PROB_W'((1 << PROB_BITS) - 1);

  logic [IdxW-1:0]   pos_q, pos_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic [PROB_W-1:0] best_val_q, best_val_d;
  logic [IdxW-1:0]   prev_q, prev_d;
  logic              prev_valid_q, prev_valid_d;

  logic [CFG_DATA_W:0] lc_eff;
  logic [CFG_DATA_W:0] lc_m1_full;
  logic [IdxW-1:0]     lc_m1;
  logic [PROB_W-1:0]   prob;
  logic                take;
  logic [PROB_W-1:0]   cur_val;
  logic [IdxW-1:0]     cur_idx;
  logic                step_end;
  logic                is_sym;
  logic                accept;

  // Clamp the label count into the supported range.
  always_comb begin
    if (label_count_i < CFG_DATA_W'(2)) begin
      lc_eff = (CFG_DATA_W + 1)'(2);
    end else if ({1'b0, label_count_i} > (CFG_DATA_W + 1)'(MAX_LABELS)) begin
      lc_eff = (CFG_DATA_W + 1)'(MAX_LABELS);
    end else begin
      lc_eff = {1'b0, label_count_i};
    end
    lc_m1_full = lc_eff - (CFG_DATA_W + 1)'(1);
    lc_m1      = lc_m1_full[IdxW-1:0];
  end

  assign prob     = in_ch.probability & ProbMask;
  assign take     = (pos_q == '0) || (prob > best_val_q);
  assign cur_val  = take ? prob : best_val_q;
  assign cur_idx  = take ? pos_q : best_idx_q;
  assign step_end = (pos_q >= lc_m1) || in_ch.end_of_sequence;
  assign is_sym   = (cur_idx != lc_m1) && (!prev_valid_q || (cur_idx != prev_q));

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_o      = accept && step_end && (is_sym || in_ch.end_of_sequence);

  always_comb begin
    ev_o.id   = ID_W'(cur_idx);
    ev_o.conf = cur_val;
    ev_o.sym  = is_sym;
    ev_o.eos  = in_ch.end_of_sequence;
  end

  always_comb begin
    pos_d        = pos_q;
    best_idx_d   = best_idx_q;
    best_val_d   = best_val_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    if (accept) begin
      if (step_end) begin
        pos_d        = '0;
        best_idx_d   = '0;
        best_val_d   = '0;
        prev_d       = cur_idx;
        prev_valid_d = 1'b1;
        // The end of a sequence forgets the previous step.
        if (in_ch.end_of_sequence) begin
          prev_d       = '0;
          prev_valid_d = 1'b0;
        end
      end else begin
        pos_d      = pos_q + IdxW'(1);
        best_idx_d = cur_idx;
        best_val_d = cur_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      best_idx_q   <= '0;
      best_val_q   <= '0;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      best_idx_q   <= best_idx_d;
      best_val_q   <= best_val_d;
      prev_q       <= prev_d;
      prev_valid_q <= prev_valid_d;
    end
  end

endmodule

// ----- src/ctcgd_queue.sv -----
// Small event queue between the front and back ends.
module ctcgd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ctcgd_pkg::event_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ctcgd_pkg::event_t data_o
);
  import ctcgd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  event_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- src/ctcgd_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module ctcgd_divider #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned StepW = $clog2(NUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [StepW-1:0]  step_q;
  logic [DEN_W-1:0]  rem_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial  = {rem_q, quo_q[NUM_W-1]};
  assign ge     = trial >= {1'b0, den_q};
  assign diff   = trial - {1'b0, den_q};
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(NUM_W);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/ctcgd_back.sv -----
// Back end: lead-symbol arbitration, result output register and summary.
module ctcgd_back #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_empty_i,
  input  ctcgd_pkg::event_t                ev_i,
  output logic                             pop_o,
  input  logic [ctcgd_pkg::LIMIT_W-1:0]    range_low_i,
  input  logic [ctcgd_pkg::LIMIT_W-1:0]    range_high_i,
  ctcgd_out_if.source                      out_ch
);
  import ctcgd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_STEPS + 1);
  localparam int unsigned SumW = PROB_W + CntW;

  back_state_e       state_q, state_d;
  lead_stage_e       stage_q, stage_d;
  logic [ID_W-1:0]   held_id_q, held_id_d;
  logic [PROB_W-1:0] held_conf_q, held_conf_d;
  logic              pa_v_q, pa_v_d;
  logic [ID_W-1:0]   pa_id_q, pa_id_d;
  logic [PROB_W-1:0] pa_conf_q, pa_conf_d;
  logic              pb_v_q, pb_v_d;
  logic [ID_W-1:0]   pb_id_q, pb_id_d;
  logic [PROB_W-1:0] pb_conf_q, pb_conf_d;
  logic              eos_q, eos_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic                  ov_q, ov_d;
  logic                  kind_q, kind_d;
  logic [LABEL_ID_W-1:0] lid_q, lid_d;
  logic [PROB_W-1:0]     conf_q, conf_d;
  logic [PROB_W-1:0]     avg_q, avg_d;
  logic                  nosym_q, nosym_d;
  logic                  last_q, last_d;

  logic            slot_free;
  logic            div_start, div_busy, div_done;
  logic [SumW-1:0] div_quot;
  logic            held_lead, ev_lead;

  ctcgd_divider #(
    .NUM_W(SumW),
    .DEN_W(CntW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (sum_q),
    .den_i  (cnt_q),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign slot_free = !ov_q || out_ch.ready;
  assign held_lead = (held_id_q < {1'b0, range_low_i}) || (held_id_q > {1'b0, range_high_i});
  assign ev_lead   = (ev_i.id < {1'b0, range_low_i}) || (ev_i.id > {1'b0, range_high_i});

  assign out_ch.valid              = ov_q;
  assign out_ch.kind               = kind_q;
  assign out_ch.label_id           = lid_q;
  assign out_ch.confidence         = conf_q;
  assign out_ch.average_confidence = avg_q;
  assign out_ch.no_symbols         = nosym_q;
  assign out_ch.last               = last_q;

  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    held_id_d   = held_id_q;
    held_conf_d = held_conf_q;
    pa_v_d      = pa_v_q;
    pa_id_d     = pa_id_q;
    pa_conf_d   = pa_conf_q;
    pb_v_d      = pb_v_q;
    pb_id_d     = pb_id_q;
    pb_conf_d   = pb_conf_q;
    eos_d       = eos_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    ov_d        = ov_q && !out_ch.ready;
    kind_d      = kind_q;
    lid_d       = lid_q;
    conf_d      = conf_q;
    avg_d       = avg_q;
    nosym_d     = nosym_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o  = 1'b1;
          eos_d  = ev_i.eos;
          pa_v_d = 1'b0;
          pb_v_d = 1'b0;
          if (ev_i.sym) begin
            case (stage_q)
              LS_NONE: begin
                held_id_d   = ev_i.id;
                held_conf_d = ev_i.conf;
                stage_d     = LS_HELD;
                // A sequence that ends here releases its lone symbol at once.
                if (ev_i.eos) begin
                  pa_v_d    = 1'b1;
                  pa_id_d   = ev_i.id;
                  pa_conf_d = ev_i.conf;
                end
              end
              LS_HELD: begin
                pa_v_d = 1'b1;
                if (held_lead && ev_lead) begin
                  // Two lead symbols: only the more confident one survives.
                  if (held_conf_q < ev_i.conf) begin
                    pa_id_d   = ev_i.id;
                    pa_conf_d = ev_i.conf;
                  end else begin
                    pa_id_d   = held_id_q;
                    pa_conf_d = held_conf_q;
                  end
                end else begin
                  pa_id_d   = held_id_q;
                  pa_conf_d = held_conf_q;
                  pb_v_d    = 1'b1;
                  pb_id_d   = ev_i.id;
                  pb_conf_d = ev_i.conf;
                end
                stage_d = LS_PASS;
              end
              default: begin
                pa_v_d    = 1'b1;
                pa_id_d   = ev_i.id;
                pa_conf_d = ev_i.conf;
              end
            endcase
          end else if (stage_q == LS_HELD) begin
            pa_v_d    = 1'b1;
            pa_id_d   = held_id_q;
            pa_conf_d = held_conf_q;
          end
          if (pa_v_d) begin
            state_d = BK_SYM;
          end else if (ev_i.eos) begin
            state_d = BK_DIV;
          end
        end
      end
      BK_SYM: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          kind_d  = KIND_SYMBOL;
          lid_d   = pa_id_q[LABEL_ID_W-1:0];
          conf_d  = pa_conf_q;
          avg_d   = '0;
          nosym_d = 1'b0;
          last_d  = 1'b0;
          if (cnt_q < CntW'(MAX_STEPS)) begin
            sum_d = sum_q + SumW'(pa_conf_q);
            cnt_d = cnt_q + CntW'(1);
          end
          if (pb_v_q) begin
            pa_id_d   = pb_id_q;
            pa_conf_d = pb_conf_q;
            pb_v_d    = 1'b0;
          end else begin
            pa_v_d  = 1'b0;
            state_d = eos_q ? BK_DIV : BK_IDLE;
          end
        end
      end
      BK_DIV: begin
        if (cnt_q == '0) begin
          state_d = BK_SUM;
        end else begin
          div_start = 1'b1;
          state_d   = BK_WAIT;
        end
      end
      BK_WAIT: begin
        if (div_done) begin
          state_d = BK_SUM;
        end
      end
      BK_SUM: begin
        if (slot_free) begin
          ov_d        = 1'b1;
          kind_d      = KIND_SUMMARY;
          lid_d       = '0;
          conf_d      = '0;
          avg_d       = (cnt_q == '0) ? '0 : div_quot[PROB_W-1:0];
          nosym_d     = (cnt_q == '0);
          last_d      = 1'b1;
          stage_d     = LS_NONE;
          held_id_d   = '0;
          held_conf_d = '0;
          sum_d       = '0;
          cnt_d       = '0;
          eos_d       = 1'b0;
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pa_id_q   <= pa_id_d;
    pa_conf_q <= pa_conf_d;
    pb_id_q   <= pb_id_d;
    pb_conf_q <= pb_conf_d;
    kind_q    <= kind_d;
    lid_q     <= lid_d;
    conf_q    <= conf_d;
    avg_q     <= avg_d;
    nosym_q   <= nosym_d;
    last_q    <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      stage_q     <= LS_NONE;
      held_id_q   <= '0;
      held_conf_q <= '0;
      pa_v_q      <= 1'b0;
      pb_v_q      <= 1'b0;
      eos_q       <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      held_id_q   <= held_id_d;
      held_conf_q <= held_conf_d;
      pa_v_q      <= pa_v_d;
      pb_v_q      <= pb_v_d;
      eos_q       <= eos_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      ov_q        <= ov_d;
    end
  end

  a_cnt_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_STEPS))
    else $error("symbol count exceeds its cap");

  a_pend_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pb_v_q |-> (pa_v_q && state_q == BK_SYM))
    else $error("second pending symbol without a first one");

  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_WAIT && !div_done) |-> div_busy)
    else $error("waiting on an idle divider");

  a_summary_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SUM && slot_free) |=>
      (stage_q == LS_NONE && cnt_q == '0 && ov_q && last_q))
    else $error("sequence state not cleared after summary");

endmodule

// ----- src/ctc_greedy_plate_decoder_core.sv -----
// Top level of the CTC greedy plate decoder: configuration registers and the two halves.
// The decoder takes one label probability per cycle, unless the event queue is full; the
// front end tracks the running argmax and, at the last label of a step that yields a symbol
// or ends a sequence, hands an event to a four-entry queue. The back end takes an event and
// then emits its pending symbols, and at the end of a sequence it runs a bit-serial divider
// for the mean confidence before presenting the summary. Input is held off only while the
// event queue is full, so steady streaming keeps one item per cycle while the queue has room.
// Configuration writes take effect at the next clock edge and should be made while idle.
module ctc_greedy_plate_decoder_core #(
  parameter int unsigned MAX_LABELS = 128,
  parameter int unsigned MAX_STEPS  = 64,
  parameter int unsigned PROB_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ctcgd_in_if.sink                          in_ch,
  ctcgd_out_if.source                       out_ch,
  input  logic                              cfg_we_i,
  input  logic [ctcgd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ctcgd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ctcgd_pkg::*;

  logic [CFG_DATA_W-1:0] label_count_q;
  logic [LIMIT_W-1:0]    range_low_q;
  logic [LIMIT_W-1:0]    range_high_q;

  logic   push, q_full, pop, q_empty;
  event_t ev_in, ev_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_count_q <= LABEL_COUNT_RST;
      range_low_q   <= RANGE_LOW_RST;
      range_high_q  <= RANGE_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LABEL_COUNT: label_count_q <= cfg_data_i;
        CFG_RANGE_LOW:   range_low_q   <= cfg_data_i[LIMIT_W-1:0];
        CFG_RANGE_HIGH:  range_high_q  <= cfg_data_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ctcgd_front #(
    .MAX_LABELS(MAX_LABELS),
    .PROB_BITS (PROB_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .label_count_i(label_count_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .ev_o         (ev_in)
  );

  ctcgd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (ev_in),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .data_o (ev_out)
  );

  ctcgd_back #(
    .MAX_STEPS(MAX_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .ev_i        (ev_out),
    .pop_o       (pop),
    .range_low_i (range_low_q),
    .range_high_i(range_high_q),
    .out_ch      (out_ch)
  );

endmodule

// ----- test/ctcgd_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the CTC greedy plate decoder: predicts and checks every result transfer.
module ctcgd_checker #(
  parameter int unsigned MAX_LABELS = 128,
  parameter int unsigned MAX_STEPS  = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ctcgd_in_if                              in_ch,
  ctcgd_out_if                             out_ch,
  input  logic                             cfg_we_i,
  input  logic [ctcgd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctcgd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_count_o,
  output int unsigned                      item_count_o,
  output int unsigned                      result_count_o,
  output int unsigned                      sequence_count_o
);
  import ctcgd_pkg::*;

  typedef struct packed {
    logic                  kind;
    logic [LABEL_ID_W-1:0] label_id;
    logic [PROB_W-1:0]     confidence;
    logic [PROB_W-1:0]     average_confidence;
    logic                  no_symbols;
    logic                  last;
  } decoded_result_t;

  decoded_result_t expected_results[$];
  decoded_result_t got_result;
  decoded_result_t want_result;

  // Shadow copy of the configuration registers.
  logic [CFG_DATA_W-1:0] lc_reg;
  logic [LIMIT_W-1:0]    low_reg;
  logic [LIMIT_W-1:0]    high_reg;

  // Shadow copy of the decoder's sequence state.
  logic [PROB_W-1:0]     run_max;
  logic [LABEL_ID_W-1:0] run_arg;
  logic [7:0]            label_pos;
  logic [LABEL_ID_W-1:0] prev_arg;
  logic                  prev_seen;
  logic [LABEL_ID_W-1:0] held_label;
  logic [PROB_W-1:0]     held_conf;
  lead_stage_e           stage;
  logic [21:0]           conf_sum;
  logic [6:0]            sym_count;

  function automatic bit is_lead_class(input logic [LABEL_ID_W-1:0] id);
    return (id < low_reg) || (id > high_reg);
  endfunction

  task automatic clear_sequence_state();
    run_max    = '0;
    run_arg    = '0;
    label_pos  = '0;
    prev_arg   = '0;
    prev_seen  = 1'b0;
    held_label = '0;
    held_conf  = '0;
    stage      = LS_NONE;
    conf_sum   = '0;
    sym_count  = '0;
  endtask

  task automatic append_expected(input decoded_result_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic emit_symbol(input logic [LABEL_ID_W-1:0] id, input logic [PROB_W-1:0] conf);
    decoded_result_t r;
    r = '0;
    r.kind       = KIND_SYMBOL;
    r.label_id   = id;
    r.confidence = conf;
    append_expected(r);
    // Past the symbol cap the symbol still goes out but no longer counts in the mean.
    if (sym_count < MAX_STEPS) begin
      conf_sum  = conf_sum + conf;
      sym_count = sym_count + 1'b1;
    end
  endtask

  task automatic decode_step(input logic [PROB_W-1:0] prob, input logic eos);
    int unsigned     lc_eff;
    decoded_result_t r;
    lc_eff = (lc_reg < 2) ? 2 : ((lc_reg > MAX_LABELS) ? MAX_LABELS : lc_reg);
    if (label_pos == 0 || prob > run_max) begin
      run_max = prob;
      run_arg = label_pos[LABEL_ID_W-1:0];
    end
    if (label_pos >= lc_eff - 1 || eos) begin
      if (run_arg != lc_eff - 1 && (!prev_seen || run_arg != prev_arg)) begin
        case (stage)
          LS_NONE: begin
            held_label = run_arg;
            held_conf  = run_max;
            stage      = LS_HELD;
          end
          LS_HELD: begin
            // Two leading symbols of the lead class: keep only the more confident one.
            if (is_lead_class(held_label) && is_lead_class(run_arg)) begin
              if (held_conf < run_max) emit_symbol(run_arg, run_max);
              else emit_symbol(held_label, held_conf);
            end else begin
              emit_symbol(held_label, held_conf);
              emit_symbol(run_arg, run_max);
            end
            stage = LS_PASS;
          end
          default: emit_symbol(run_arg, run_max);
        endcase
      end
      prev_arg  = run_arg;
      prev_seen = 1'b1;
      label_pos = '0;
      run_max   = '0;
      run_arg   = '0;
    end else begin
      label_pos = label_pos + 1'b1;
    end
    if (eos) begin
      if (stage == LS_HELD) emit_symbol(held_label, held_conf);
      r = '0;
      r.kind = KIND_SUMMARY;
      r.last = 1'b1;
      if (sym_count == 0) r.no_symbols = 1'b1;
      else r.average_confidence = 16'(conf_sum / sym_count);
      append_expected(r);
      clear_sequence_state();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_reg   = LABEL_COUNT_RST;
      low_reg  = RANGE_LOW_RST;
      high_reg = RANGE_HIGH_RST;
      clear_sequence_state();
      expected_results.delete();
      fail_count_o     = 0;
      pending_count_o  = 0;
      item_count_o     = 0;
      result_count_o   = 0;
      sequence_count_o = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        result_count_o++;
        got_result.kind               = out_ch.kind;
        got_result.label_id           = out_ch.label_id;
        got_result.confidence         = out_ch.confidence;
        got_result.average_confidence = out_ch.average_confidence;
        got_result.no_symbols         = out_ch.no_symbols;
        got_result.last               = out_ch.last;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: kind %0d label_id %0d",
                 got_result.kind, got_result.label_id);
          fail_count_o++;
        end else begin
          want_result = expected_results.pop_front();
          check_field("kind", want_result.kind, got_result.kind);
          check_field("label_id", want_result.label_id, got_result.label_id);
          check_field("confidence", want_result.confidence, got_result.confidence);
          check_field("average_confidence", want_result.average_confidence,
                      got_result.average_confidence);
          check_field("no_symbols", want_result.no_symbols, got_result.no_symbols);
          check_field("last", want_result.last, got_result.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        item_count_o++;
        if (in_ch.end_of_sequence) sequence_count_o++;
        decode_step(in_ch.probability, in_ch.end_of_sequence);
      end
      // A write lands after any transfer of the same edge has used the old value.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LABEL_COUNT: lc_reg   = cfg_data_i;
          CFG_RANGE_LOW:   low_reg  = cfg_data_i[LIMIT_W-1:0];
          CFG_RANGE_HIGH:  high_reg = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      pending_count_o = expected_results.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top of the decoder testbench: clock, reset, stimulus, receiver stalls and the verdict.
module testbench;
  import ctcgd_pkg::*;

  localparam int unsigned MAX_LABELS    = 128;
  localparam int unsigned MAX_STEPS     = 64;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_ITEMS  = 160;
  localparam int unsigned CAP_STEPS     = 70;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned item_count;
  int unsigned result_count;
  int unsigned sequence_count;
  int unsigned stall_cycles;

  int unsigned burst_left;
  bit          no_gaps;
  bit          hold_req;
  int          last_winner;

  // Directed items as {end_of_sequence, probability}; the label count is 4 here.
  logic [16:0] directed_items [26] = '{
    17'h1_1234,
    17'h0_4000, 17'h0_0000, 17'h0_0000, 17'h0_0000,
    17'h0_0000, 17'h0_0000, 17'h0_C000, 17'h1_0000,
    17'h0_7000, 17'h0_7000, 17'h0_0000, 17'h0_0000,
    17'h0_0000, 17'h0_0000, 17'h0_7000, 17'h0_7000, 17'h1_FFFF,
    17'h0_0000, 17'h0_FFFF, 17'h0_0000, 17'h0_0000,
    17'h0_0000, 17'h0_0000, 17'h0_0000, 17'h1_FFFF
  };

  ctcgd_in_if  prob_ch ();
  ctcgd_out_if result_ch ();

  ctc_greedy_plate_decoder_core #(
    .MAX_LABELS(MAX_LABELS),
    .MAX_STEPS (MAX_STEPS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (prob_ch),
    .out_ch    (result_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  ctcgd_checker #(
    .MAX_LABELS(MAX_LABELS),
    .MAX_STEPS (MAX_STEPS)
  ) result_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_ch           (prob_ch),
    .out_ch          (result_ch),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count),
    .item_count_o    (item_count),
    .result_count_o  (result_count),
    .sequence_count_o(sequence_count)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int effective_count(input logic [7:0] v);
    if (v < 2) return 2;
    if (v > MAX_LABELS) return MAX_LABELS;
    return v;
  endfunction

  // Offers one item and returns at the falling edge after its transfer.
  task automatic send_item(input logic [PROB_W-1:0] p, input logic eos);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        prob_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    prob_ch.valid           <= 1'b1;
    prob_ch.probability     <= p;
    prob_ch.end_of_sequence <= eos;
    do @(posedge clk_i); while (!prob_ch.ready);
    @(negedge clk_i);
  endtask

  // Sends labels 0..stop_at of one time step; a pick of 0 or more forces a clean winner.
  task automatic send_step(input int lc, input int stop_at, input bit end_seq, input int pick);
    int              w;
    logic [PROB_W-1:0] wp;
    logic [PROB_W-1:0] p;
    bit              noise;
    noise = (pick < 0) && ($urandom_range(0, 9) < 3);
    if (pick >= 0) begin
      w = pick;
    end else begin
      case ($urandom_range(0, 6))
        0:       w = lc - 1;
        1:       w = last_winner % lc;
        default: w = $urandom_range(0, lc - 1);
      endcase
    end
    wp = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF));
    for (int i = 0; i <= stop_at; i++) begin
      if (noise) p = 16'($urandom);
      else if (i == w) p = wp;
      else if (pick < 0 && $urandom_range(0, 9) == 0) p = wp;
      else p = 16'($urandom_range(0, wp - 1));
      send_item(p, end_seq && (i == stop_at));
    end
    last_winner = w;
  endtask

  task automatic send_sequence(input int lc, input int steps, input bit broken);
    int cut;
    for (int s = 0; s < steps; s++) begin
      if (s == steps - 1) begin
        cut = broken ? $urandom_range(0, lc - 1) : lc - 1;
        send_step(lc, cut, 1'b1, -1);
      end else begin
        send_step(lc, lc - 1, 1'b0, -1);
      end
    end
  endtask

  // Stops offering until every expected result has arrived, then lets the back end settle.
  task automatic drain_block();
    prob_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] lc, input logic [6:0] lo, input logic [6:0] hi);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_LABEL_COUNT;
    cfg_data <= lc;
    @(negedge clk_i);
    cfg_idx  <= CFG_RANGE_LOW;
    cfg_data <= {1'b0, lo};
    @(negedge clk_i);
    cfg_idx  <= CFG_RANGE_HIGH;
    cfg_data <= {1'b0, hi};
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Receiver: random stall patterns, plus one long hold-off on request.
  initial begin
    int unsigned seg_left;
    int unsigned stall_mode;
    bit          hold_done;
    seg_left   = 0;
    stall_mode = 0;
    hold_done  = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          seg_left   = $urandom_range(5, 60);
        end
        seg_left--;
        case (stall_mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= 1'($urandom_range(0, 1));
          default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (prob_ch.valid && prob_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Watchdog: no transfer for %0d cycles.", STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int          phase;
    int          lc_eff;
    int unsigned random_start;
    logic [7:0]  lc_w;
    logic [6:0]  lo;
    logic [6:0]  hi;
    rst_ni                  = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = CFG_LABEL_COUNT;
    cfg_data                = '0;
    prob_ch.valid           = 1'b0;
    prob_ch.probability     = '0;
    prob_ch.end_of_sequence = 1'b0;
    burst_left              = 0;
    no_gaps                 = 1'b0;
    hold_req                = 1'b0;
    last_winner             = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: early end, two lead symbols, ties, a blank and a lone held symbol.
    write_config(8'd4, 7'd1, 7'd1);
    foreach (directed_items[i]) send_item(directed_items[i][15:0], directed_items[i][16]);
    drain_block();

    random_start = item_count;
    phase        = 0;
    while (phase < 5 || item_count < random_start + RANDOM_ITEMS) begin
      drain_block();
      case (phase)
        0: begin lc_w = 8'd0;   lo = 7'd0;   hi = 7'd0;   end
        1: begin lc_w = 8'd128; lo = 7'd31;  hi = 7'd63;  end
        2: begin lc_w = 8'd1;   lo = 7'd127; hi = 7'd0;   end
        3: begin lc_w = 8'd3;   lo = 7'd0;   hi = 7'd127; end
        4: begin lc_w = 8'd255; lo = 7'd127; hi = 7'd127; end
        default: begin
          lc_w   = 8'($urandom_range(2, 12));
          lc_eff = effective_count(lc_w);
          case ($urandom_range(0, 4))
            0: begin lo = 7'd0;   hi = 7'd127; end
            1: begin lo = 7'd127; hi = 7'd0;   end
            default: begin
              lo = 7'($urandom_range(0, lc_eff));
              hi = 7'($urandom_range(0, lc_eff));
            end
          endcase
        end
      endcase
      lc_eff = effective_count(lc_w);
      write_config(lc_w, lo, hi);
      case (phase)
        1: begin
          send_step(lc_eff, lc_eff - 1, 1'b0, -1);
          send_step(lc_eff, $urandom_range(0, 30), 1'b1, -1);
        end
        3: begin
          // Alternating symbols run past the cap while the receiver holds off.
          hold_req = 1'b1;
          no_gaps  = 1'b1;
          for (int s = 0; s < CAP_STEPS; s++) begin
            send_step(lc_eff, lc_eff - 1, s == CAP_STEPS - 1, s % 2);
          end
          no_gaps  = 1'b0;
        end
        4: send_step(lc_eff, $urandom_range(0, 40), 1'b1, -1);
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            // Break off in the middle of a step and change the label count before going on.
            send_step(lc_eff, $urandom_range(0, lc_eff - 2), 1'b0, -1);
            drain_block();
            lc_w   = 8'($urandom_range(0, 8));
            lc_eff = effective_count(lc_w);
            write_config(lc_w, lo, hi);
          end
          repeat ($urandom_range(1, 3)) begin
            send_sequence(lc_eff, $urandom_range(1, 8), $urandom_range(0, 4) == 0);
          end
        end
      endcase
      phase++;
    end

    drain_block();
    $display("Checked %0d results from %0d probability transfers in %0d sequences.",
             result_count, item_count, sequence_count);
    $display("Label counts spanned 2 to 128 with extreme and crossed limits and a capped sequence.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
